[rtl/tmb_pkg.sv]
// Shared constants, request codes and types for the timer bank.
`default_nettype none

package tmb_pkg;

  // Bank sizes and counter width
  localparam int NUM_PERIODIC = 8;
  localparam int NUM_TIMEOUTS = 8;
  localparam int COUNT_WIDTH  = 32;

  // Port widths fixed by the interface
  localparam int REQ_W   = 3;
  localparam int CH_W    = 3;
  localparam int LEN_W   = 32;
  localparam int MARK_W  = 8;
  localparam int USE_W   = 4;
  // In-use counts after clamping; holds values up to 63
  localparam int EFF_W   = 6;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_IN_USE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUTS_IN_USE = 1'b1;
  localparam logic [USE_W-1:0]     USE_RESET           = 4'd8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR_END = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd4;

  // Request handed from the input stage to both banks
  typedef struct packed {
    logic                   apply;
    logic [REQ_W-1:0]       kind;
    logic [CH_W-1:0]        ch;
    logic [COUNT_WIDTH-1:0] len;
  } tmb_req_t;

endpackage

`default_nettype wire

[rtl/tmb_period_bank.sv]
// Periodic timers: count, reload length, active and end marks per channel.
`default_nettype none

module tmb_period_bank
  import tmb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tmb_req_t                req,
  input  wire logic [EFF_W-1:0]        eff_count,
  output logic      [NUM_PERIODIC-1:0] end_nxt,
  output logic      [NUM_PERIODIC-1:0] active_nxt
);

  logic [COUNT_WIDTH-1:0] count_r  [NUM_PERIODIC];
  logic [COUNT_WIDTH-1:0] length_r [NUM_PERIODIC];
  logic [NUM_PERIODIC-1:0] active_r;
  logic [NUM_PERIODIC-1:0] end_r;

  genvar i;
  generate
    for (i = 0; i < NUM_PERIODIC; i++) begin : g_chan
      logic                   in_use;
      logic                   hit;
      logic                   tick;
      logic [COUNT_WIDTH-1:0] dec;
      logic [COUNT_WIDTH-1:0] count_nxt;
      logic [COUNT_WIDTH-1:0] length_nxt;

      assign in_use = EFF_W'(i) < eff_count;
      assign hit    = req.apply && in_use && ({{(EFF_W-CH_W){1'b0}}, req.ch} == EFF_W'(i));
      assign tick   = req.apply && in_use && active_r[i] && (req.kind == REQ_TICK);
      assign dec    = count_r[i] - COUNT_WIDTH'(1);

      always_comb begin
        count_nxt     = count_r[i];
        length_nxt    = length_r[i];
        active_nxt[i] = active_r[i];
        end_nxt[i]    = end_r[i];
        if (tick) begin
          if (dec == '0) begin
            end_nxt[i] = 1'b1;
            count_nxt  = length_r[i];
          end else begin
            count_nxt  = dec;
          end
        end else if (hit) begin
          if (req.kind == REQ_START) begin
            active_nxt[i] = 1'b1;
            length_nxt    = req.len;
            count_nxt     = req.len;
          end else if (req.kind == REQ_CLEAR_END) begin
            end_nxt[i] = 1'b0;
          end else if (req.kind == REQ_STOP) begin
            active_nxt[i] = 1'b0;
          end
        end
      end

      always_ff @(posedge clk) begin
        count_r[i]  <= count_nxt;
        length_r[i] <= length_nxt;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      end_r    <= '0;
    end else begin
      active_r <= active_nxt;
      end_r    <= end_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/tmb_timeout_bank.sv]
// One-shot timeout counters that count down to zero on ticks.
`default_nettype none

module tmb_timeout_bank
  import tmb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tmb_req_t                req,
  input  wire logic [EFF_W-1:0]        eff_count,
  output logic      [NUM_TIMEOUTS-1:0] expired_nxt
);

  logic [COUNT_WIDTH-1:0] count_r   [NUM_TIMEOUTS];
  logic [COUNT_WIDTH-1:0] count_nxt [NUM_TIMEOUTS];

  genvar i;
  generate
    for (i = 0; i < NUM_TIMEOUTS; i++) begin : g_chan
      logic in_use;
      logic hit;

      assign in_use = EFF_W'(i) < eff_count;
      assign hit    = req.apply && in_use && ({{(EFF_W-CH_W){1'b0}}, req.ch} == EFF_W'(i));

      always_comb begin
        count_nxt[i] = count_r[i];
        if (req.apply && in_use && (req.kind == REQ_TICK) && (count_r[i] != '0)) begin
          count_nxt[i] = count_r[i] - COUNT_WIDTH'(1);
        end else if (hit && (req.kind == REQ_LOAD)) begin
          count_nxt[i] = req.len;
        end
      end

      assign expired_nxt[i] = (count_nxt[i] == '0);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          count_r[i] <= '0;
        end else begin
          count_r[i] <= count_nxt[i];
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

[rtl/periodic_and_timeout_timer_bank.sv]
// Top level: request register, periodic and timeout banks, result register.
`default_nettype none

// Bank of 8 periodic timers and 8 one-shot timeouts, 32-bit counts. Each
// request (tick, start period, clear end mark, stop period, load timeout)
// returns one result: end marks, active marks and expired-timeout marks as
// seen after the request took effect. Throughput is one request per cycle
// while the result is not stalled: the request is captured in the input
// register at its transfer edge, then all counters update in parallel in
// one pass and the mark vectors land in the result register when the
// request is applied.
// A stalled result holds the pipe; the input register still takes one more
// request behind it. periods_in_use / timeouts_in_use (cfg index 0 / 1,
// reset 8, values above 8 act as 8) limit which channels ticks update and
// which indexes requests accept; an index at or above the in-use count is
// ignored. Request codes 5..7 change nothing and just report the marks.
// Write config only while the block is idle.

module periodic_and_timeout_timer_bank
  import tmb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // config write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [USE_W-1:0]     cfg_wdata,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [CH_W-1:0]      in_channel_index,
  input  wire logic [LEN_W-1:0]     in_length_value,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [MARK_W-1:0]         out_period_end_marks,
  output logic [MARK_W-1:0]         out_period_active_marks,
  output logic [MARK_W-1:0]         out_timeout_expired_marks
);

  // Config registers
  logic [USE_W-1:0] periods_in_use_r;
  logic [USE_W-1:0] timeouts_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periods_in_use_r  <= USE_RESET;
      timeouts_in_use_r <= USE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIODS_IN_USE:  periods_in_use_r  <= cfg_wdata;
        CFG_TIMEOUTS_IN_USE: timeouts_in_use_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp in-use counts to the bank sizes
  logic [EFF_W-1:0] eff_periods;
  logic [EFF_W-1:0] eff_timeouts;
  logic [EFF_W-1:0] use_p_ext;
  logic [EFF_W-1:0] use_t_ext;

  assign use_p_ext    = {{(EFF_W-USE_W){1'b0}}, periods_in_use_r};
  assign use_t_ext    = {{(EFF_W-USE_W){1'b0}}, timeouts_in_use_r};
  assign eff_periods  = (use_p_ext > EFF_W'(NUM_PERIODIC)) ? EFF_W'(NUM_PERIODIC) : use_p_ext;
  assign eff_timeouts = (use_t_ext > EFF_W'(NUM_TIMEOUTS)) ? EFF_W'(NUM_TIMEOUTS) : use_t_ext;

  // Input register stage
  logic                   s1_valid_r;
  logic [REQ_W-1:0]       s1_kind_r;
  logic [CH_W-1:0]        s1_ch_r;
  logic [COUNT_WIDTH-1:0] s1_len_r;
  logic                   s1_adv;     // request applies to state this cycle
  logic                   in_xfer;

  // result register moves when empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_req_type;
      s1_ch_r   <= in_channel_index;
      s1_len_r  <= in_length_value[COUNT_WIDTH-1:0];
    end
  end

  // Request to both banks; state only changes on s1_adv
  tmb_req_t bank_req;
  assign bank_req = '{apply: s1_adv, kind: s1_kind_r, ch: s1_ch_r, len: s1_len_r};

  logic [NUM_PERIODIC-1:0] end_nxt;
  logic [NUM_PERIODIC-1:0] active_nxt;
  logic [NUM_TIMEOUTS-1:0] expired_nxt;

  tmb_period_bank u_period (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (bank_req),
    .eff_count  (eff_periods),
    .end_nxt    (end_nxt),
    .active_nxt (active_nxt)
  );

  tmb_timeout_bank u_timeout (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (bank_req),
    .eff_count   (eff_timeouts),
    .expired_nxt (expired_nxt)
  );

  // Map bank vectors onto the 8-bit result fields; missing channels read zero
  logic [MARK_W-1:0] end_marks;
  logic [MARK_W-1:0] active_marks;
  logic [MARK_W-1:0] expired_marks;

  genvar k;
  generate
    for (k = 0; k < MARK_W; k++) begin : g_map
      if (k < NUM_PERIODIC) begin : g_p
        assign end_marks[k]    = end_nxt[k];
        assign active_marks[k] = active_nxt[k];
      end else begin : g_pz
        assign end_marks[k]    = 1'b0;
        assign active_marks[k] = 1'b0;
      end
      if (k < NUM_TIMEOUTS) begin : g_t
        assign expired_marks[k] = expired_nxt[k];
      end else begin : g_tz
        assign expired_marks[k] = 1'b0;
      end
    end
  endgenerate

  // Result register
  logic              out_valid_r;
  logic [MARK_W-1:0] end_marks_r;
  logic [MARK_W-1:0] active_marks_r;
  logic [MARK_W-1:0] expired_marks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      end_marks_r     <= end_marks;
      active_marks_r  <= active_marks;
      expired_marks_r <= expired_marks;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_period_end_marks      = end_marks_r;
  assign out_period_active_marks   = active_marks_r;
  assign out_timeout_expired_marks = expired_marks_r;

  // Checks

  // A new request never lands on a held one that has not moved on
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && s1_valid_r) |-> s1_adv)
    else $error("input register overwritten before its request was applied");

  // Every applied request produces a result next cycle
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("applied request produced no result");

  // Clamped in-use counts stay within the banks
  a_eff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (eff_periods <= EFF_W'(NUM_PERIODIC)) && (eff_timeouts <= EFF_W'(NUM_TIMEOUTS)))
    else $error("in-use count exceeds bank size");

  // A stalled result stays valid and unchanged
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(end_marks_r) &&
      $stable(active_marks_r) && $stable(expired_marks_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire
